// ===== design/sfd_pkg.sv =====
// Shared types, widths and coefficient table of the symmetric FIR decimator.
// No dependencies; every other design file imports this package.
package sfd_pkg;

  localparam int TAP_COUNT           = 31;
  localparam int HALF_TAPS           = (TAP_COUNT - 1) / 2;
  localparam int PROD_COUNT          = HALF_TAPS + 1;
  localparam int GROUP_SIZE          = 4;
  localparam int GROUP_COUNT         = PROD_COUNT / GROUP_SIZE;
  localparam int COEFF_FRACTION_BITS = 15;

  localparam int RAW_W    = 12;
  localparam int SAMPLE_W = 13;  // raw code minus offset: -4095..4095
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int COEFF_W  = 15;
  localparam int PROD_W   = PAIR_W + COEFF_W;  // also bounds the whole dot product
  localparam int OUT_W    = 16;
  localparam int CODE_W   = 12;
  localparam int DEC_W    = 8;
  localparam int SKIP_W   = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_SKIP  = 2'd2;

  localparam logic [RAW_W-1:0]  DC_OFFSET_RST    = 12'd2048;
  localparam logic [DEC_W-1:0]  DECIMATION_RST   = 8'd3;
  localparam logic [SKIP_W-1:0] STARTUP_SKIP_RST = 10'd30;

  localparam int CODE_BIAS = 2048;
  localparam int CODE_MAX  = 4095;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // Half of the symmetric impulse response; the last entry is the center tap.
  function automatic coeff_t coeff(input int idx);
    coeff_t c;
    case (idx)
      0:       c = -15'sd24;
      1:       c = -15'sd15;
      2:       c = 15'sd65;
      3:       c = 15'sd132;
      4:       c = 15'sd9;
      5:       c = -15'sd284;
      6:       c = -15'sd350;
      7:       c = 15'sd160;
      8:       c = 15'sd847;
      9:       c = 15'sd651;
      10:      c = -15'sd833;
      11:      c = -15'sd2172;
      12:      c = -15'sd921;
      13:      c = 15'sd3751;
      14:      c = 15'sd9401;
      15:      c = 15'sd11934;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/sfd_tap_cell.sv =====
// One delay-line cell: holds a sample and hands it to the next cell on a shift.
// Depends on sfd_pkg for the sample type.
module sfd_tap_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            clr_i,
  input  sfd_pkg::sample_t d_i,
  output sfd_pkg::sample_t q_o
);
  import sfd_pkg::*;

  sample_t tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (en_i) begin
      tap_q <= clr_i ? '0 : d_i;
    end
  end

  assign q_o = tap_q;

endmodule

// ===== design/sfd_pair_mac.sv =====
// Folded tap pair: adds two mirrored samples and scales by a shared coefficient.
// Depends on sfd_pkg for sample, coefficient and product types.
module sfd_pair_mac (
  input  logic             clk_i,
  input  logic             en_i,
  input  sfd_pkg::sample_t a_i,
  input  sfd_pkg::sample_t b_i,
  input  sfd_pkg::coeff_t  coeff_i,
  output sfd_pkg::prod_t   prod_o
);
  import sfd_pkg::*;

  logic signed [PAIR_W-1:0] pair;
  prod_t prod_d, prod_q;

  assign pair   = PAIR_W'(a_i) + PAIR_W'(b_i);
  assign prod_d = PROD_W'(pair) * PROD_W'(coeff_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== design/sfd_adder_tree.sv =====
// Two-stage registered adder tree over the folded tap products.
// Depends on sfd_pkg for the product type and group sizes.
module sfd_adder_tree (
  input  logic           clk_i,
  input  logic           en_a_i,
  input  logic           en_b_i,
  input  sfd_pkg::prod_t prod_i [sfd_pkg::PROD_COUNT],
  output sfd_pkg::prod_t acc_o
);
  import sfd_pkg::*;

  prod_t grp_d [GROUP_COUNT];
  prod_t grp_q [GROUP_COUNT];
  prod_t acc_d, acc_q;

  // Partial sums never exceed the bound of the full sum, so PROD_W holds them.
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_d[g] = grp_d[g] + prod_i[g*GROUP_SIZE + k];
      end
    end
  end

  always_comb begin
    acc_d = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      acc_d = acc_d + grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      grp_q <= grp_d;
    end
    if (en_b_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== design/sfd_post.sv =====
// Output stage: round half away from zero, drop fraction bits, re-bias and clamp.
// Depends on sfd_pkg for widths and output constants.
module sfd_post (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  sfd_pkg::prod_t                   acc_i,
  output logic [sfd_pkg::CODE_W-1:0]       code_o,
  output logic signed [sfd_pkg::OUT_W-1:0] signed_o
);
  import sfd_pkg::*;

  localparam int RND_W = PROD_W - COEFF_FRACTION_BITS;

  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rnd;
  logic [RND_W-1:0]         rnd_q15;
  logic signed [OUT_W-1:0]  y;
  logic signed [OUT_W:0]    biased;
  logic [CODE_W-1:0]        code_d;
  logic [CODE_W-1:0]        code_q;
  logic signed [OUT_W-1:0]  y_q;

  // The sum is bounded well inside 16 bits after the shift, so no saturation arm.
  always_comb begin
    neg     = acc_i[PROD_W-1];
    mag     = neg ? (~acc_i + 1'b1) : acc_i;
    rnd     = mag + (PROD_W'(1) << (COEFF_FRACTION_BITS - 1));
    rnd_q15 = rnd[PROD_W-1:COEFF_FRACTION_BITS];
    y       = neg ? -OUT_W'(rnd_q15) : OUT_W'(rnd_q15);
    biased  = (OUT_W+1)'(y) + (OUT_W+1)'(CODE_BIAS);
    if (biased > (OUT_W+1)'(CODE_MAX)) begin
      code_d = CODE_W'(CODE_MAX);
    end else if (biased < 0) begin
      code_d = '0;
    end else begin
      code_d = biased[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
      y_q    <= y;
    end
  end

  assign code_o   = code_q;
  assign signed_o = y_q;

endmodule

// ===== design/symmetric_fir_decimator.sv =====
// Symmetric 31-tap Q15 FIR decimator built as a row of delay-line cells.
// Pipeline: a sample passes taps, products, group sums, total and output register to out_valid_o.
// Throughput: one sample per cycle while in_stall_o is low; the five register stages advance on their own,
// so an item is taken while a finished result waits, until all stages are full.
// Reset: delay line, counters and valid bits clear; registers take default values.
module symmetric_fir_decimator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sfd_pkg::RAW_W-1:0]            raw_sample_i,
  input  logic                                 start_of_block_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sfd_pkg::CODE_W-1:0]           filtered_code_o,
  output logic signed [sfd_pkg::OUT_W-1:0]     filtered_signed_o
);
  import sfd_pkg::*;

  logic [RAW_W-1:0]  dc_offset_q;
  logic [DEC_W-1:0]  decimation_q;
  logic [SKIP_W-1:0] startup_skip_q;

  logic [SKIP_W-1:0] startup_cnt_q, startup_cnt_d, cnt_base;
  logic [DEC_W-1:0]  phase_q, phase_d, phase_base, phase_inc;
  logic              emit_d, emit_q;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en0, en1, en2, en3, en_out;
  logic accept;

  sample_t new_sample;
  sample_t tap [TAP_COUNT];
  prod_t   prod [PROD_COUNT];
  prod_t   acc;

  // Stage enables: a stage loads when it is empty or its successor moves on.
  assign en_out     = !v4_q || !out_stall_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_stall_o = !en0;
  assign accept     = in_valid_i && en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_offset_q    <= DC_OFFSET_RST;
      decimation_q   <= DECIMATION_RST;
      startup_skip_q <= STARTUP_SKIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DC_OFFSET:    dc_offset_q    <= cfg_wdata_i[RAW_W-1:0];
        CFG_DECIMATION:   decimation_q   <= cfg_wdata_i[DEC_W-1:0];
        CFG_STARTUP_SKIP: startup_skip_q <= cfg_wdata_i[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Startup suppression and decimation phase, decided when the item is taken.
  always_comb begin
    cnt_base      = start_of_block_i ? '0 : startup_cnt_q;
    phase_base    = start_of_block_i ? '0 : phase_q;
    phase_inc     = phase_base + 1'b1;
    startup_cnt_d = cnt_base;
    phase_d       = phase_base;
    emit_d        = 1'b0;
    if (cnt_base < startup_skip_q) begin
      startup_cnt_d = cnt_base + 1'b1;
    end else if (decimation_q == '0) begin
      phase_d = '0;
    end else begin
      emit_d  = (phase_base == '0);
      phase_d = (phase_inc >= decimation_q) ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_cnt_q <= '0;
      phase_q       <= '0;
      emit_q        <= 1'b0;
      v0_q          <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      v4_q          <= 1'b0;
    end else begin
      if (accept) begin
        startup_cnt_q <= startup_cnt_d;
        phase_q       <= phase_d;
        emit_q        <= emit_d;
      end
      if (en0) begin
        v0_q <= in_valid_i;
      end
      // Drop suppressed items here; only emitted ones fill later stages.
      if (en1) begin
        v1_q <= v0_q && emit_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        v4_q <= v3_q;
      end
    end
  end

  assign new_sample = sample_t'({1'b0, raw_sample_i}) - sample_t'({1'b0, dc_offset_q});

  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
    if (i == 0) begin : g_head
      sfd_tap_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .clr_i  (1'b0),
        .d_i    (new_sample),
        .q_o    (tap[i])
      );
    end else begin : g_body
      sfd_tap_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .clr_i  (start_of_block_i),
        .d_i    (tap[i-1]),
        .q_o    (tap[i])
      );
    end
  end

  for (genvar i = 0; i < PROD_COUNT; i++) begin : g_mac
    if (i == HALF_TAPS) begin : g_center
      sfd_pair_mac u_mac (
        .clk_i   (clk_i),
        .en_i    (en1),
        .a_i     (tap[i]),
        .b_i     ('0),
        .coeff_i (coeff(i)),
        .prod_o  (prod[i])
      );
    end else begin : g_pair
      sfd_pair_mac u_mac (
        .clk_i   (clk_i),
        .en_i    (en1),
        .a_i     (tap[i]),
        .b_i     (tap[TAP_COUNT-1-i]),
        .coeff_i (coeff(i)),
        .prod_o  (prod[i])
      );
    end
  end

  sfd_adder_tree u_tree (
    .clk_i  (clk_i),
    .en_a_i (en2),
    .en_b_i (en3),
    .prod_i (prod),
    .acc_o  (acc)
  );

  sfd_post u_post (
    .clk_i    (clk_i),
    .en_i     (en_out),
    .acc_i    (acc),
    .code_o   (filtered_code_o),
    .signed_o (filtered_signed_o)
  );

  assign out_valid_o = v4_q;

endmodule
